// ----- hdl/bba_pkg.sv -----
// Buddy block allocator package: sizes, codes, command and status types.
// Shared by the interfaces, the controller, the datapath and the top level.
// No dependencies.
package bba_pkg;

    localparam int MIN_SHIFT   = 10;               // log2 of smallest block bytes
    localparam int UNIT_BITS   = 10;               // log2 of small block count
    localparam int LEVELS      = 11;
    localparam int LVL_W       = 4;
    localparam int IDX_W       = UNIT_BITS;
    localparam int HEAP_W      = 21;
    localparam int ADDR_W      = 64;
    localparam int REQ_W       = 32;
    localparam int CNT_W       = 11;
    localparam int WORD_W      = 32;
    localparam int BIT_W       = 5;
    localparam int BM_WORDS    = 68;               // bitmap words over all levels
    localparam int BM_AW       = 7;
    localparam int SC_DEPTH    = 1 << UNIT_BITS;
    localparam int CLS_W       = 4;
    localparam int CFG_IDX_W   = 1;

    localparam logic [LVL_W-1:0]     TOP_LEVEL   = LVL_W'(LEVELS - 1);
    localparam logic [CLS_W-1:0]     CLASS_EMPTY = 4'hF;
    localparam logic [UNIT_BITS-1:0] CLEAR_LAST  = UNIT_BITS'(SC_DEPTH - 1);

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_NO_SPACE  = 2'd2;
    localparam logic [1:0] ST_BAD_FREE  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LATCH,
        OP_SEL,
        OP_SCAN_RD,
        OP_SCAN_TAKE,
        OP_SCAN_NEXT,
        OP_SPLIT_RD,
        OP_SPLIT_WR,
        OP_ALLOC_FIN,
        OP_CLS_RD,
        OP_CLS_TAKE,
        OP_MERGE_RD,
        OP_MERGE_WR,
        OP_FREE_FIN,
        OP_PUSH
    } t_op;

    typedef struct packed {
        logic in_ready;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_kind;
        logic clear_last;
        logic sel_fail;
        logic word_hit;
        logic split_more;
        logic range_bad;
        logic cls_bad;
        logic merge_more;
        logic out_free;
    } t_sts;

    // First bitmap word of each level
    function automatic logic [BM_AW-1:0] level_base(input logic [LVL_W-1:0] lvl);
        logic [BM_AW-1:0] b;
        case (lvl)
            4'd0:    b = 7'd0;
            4'd1:    b = 7'd32;
            4'd2:    b = 7'd48;
            4'd3:    b = 7'd56;
            4'd4:    b = 7'd60;
            4'd5:    b = 7'd62;
            4'd6:    b = 7'd63;
            4'd7:    b = 7'd64;
            4'd8:    b = 7'd65;
            4'd9:    b = 7'd66;
            default: b = 7'd67;
        endcase
        return b;
    endfunction

    // Block bytes at a level
    function automatic logic [HEAP_W-1:0] blk_bytes(input logic [LVL_W-1:0] lvl);
        return HEAP_W'(1 << MIN_SHIFT) << lvl;
    endfunction

endpackage

// ----- hdl/bba_if.sv -----
// Channel interfaces of the buddy block allocator: request, response, config.
// Depends on bba_pkg.
interface bba_req_if;
    import bba_pkg::*;
    logic                valid;
    logic                ready;
    logic                kind;
    logic [REQ_W-1:0]    request_bytes;
    logic [ADDR_W-1:0]   free_address;
    modport source (output valid, kind, request_bytes, free_address, input ready);
    modport sink   (input valid, kind, request_bytes, free_address, output ready);
endinterface

interface bba_rsp_if;
    import bba_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [ADDR_W-1:0]   block_address;
    modport source (output valid, status, block_address, input ready);
    modport sink   (input valid, status, block_address, output ready);
endinterface

interface bba_cfg_if;
    import bba_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/bba_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read one address per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/bba_ctrl.sv -----
// Sequencer of the buddy block allocator: clearing pass, allocate scan and
// split, free lookup and merge. Depends on bba_pkg.
module bba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bba_pkg::t_sts i_sts,
    output bba_pkg::t_cmd o_cmd
);
    import bba_pkg::*;

    typedef enum logic [13:0] {
        S_CLEAR     = 14'b00000000000001,
        S_IDLE      = 14'b00000000000010,
        S_SEL       = 14'b00000000000100,
        S_SCAN_RD   = 14'b00000000001000,
        S_SCAN_CHK  = 14'b00000000010000,
        S_SPLIT_RD  = 14'b00000000100000,
        S_SPLIT_WR  = 14'b00000001000000,
        S_ALLOC_FIN = 14'b00000010000000,
        S_CLS_RD    = 14'b00000100000000,
        S_CLS_TAKE  = 14'b00001000000000,
        S_MERGE_RD  = 14'b00010000000000,
        S_MERGE_WR  = 14'b00100000000000,
        S_FREE_FIN  = 14'b01000000000000,
        S_RESULT    = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command
    always_comb begin
        n_state         = r_state;
        o_cmd.in_ready  = 1'b0;
        o_cmd.op        = OP_NONE;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_sts.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.op       = OP_LATCH;
                if (i_sts.in_valid) n_state = i_sts.in_kind ? S_CLS_RD : S_SEL;
            end
            S_SEL: begin
                o_cmd.op = OP_SEL;
                n_state  = i_sts.sel_fail ? S_RESULT : S_SCAN_RD;
            end
            S_SCAN_RD: begin
                o_cmd.op = OP_SCAN_RD;
                n_state  = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (i_sts.word_hit) begin
                    o_cmd.op = OP_SCAN_TAKE;
                    n_state  = i_sts.split_more ? S_SPLIT_RD : S_ALLOC_FIN;
                end else begin
                    o_cmd.op = OP_SCAN_NEXT;
                    n_state  = S_SCAN_RD;
                end
            end
            S_SPLIT_RD: begin
                o_cmd.op = OP_SPLIT_RD;
                n_state  = S_SPLIT_WR;
            end
            S_SPLIT_WR: begin
                o_cmd.op = OP_SPLIT_WR;
                n_state  = i_sts.split_more ? S_SPLIT_RD : S_ALLOC_FIN;
            end
            S_ALLOC_FIN: begin
                o_cmd.op = OP_ALLOC_FIN;
                n_state  = S_RESULT;
            end
            S_CLS_RD: begin
                o_cmd.op = OP_CLS_RD;
                n_state  = i_sts.range_bad ? S_RESULT : S_CLS_TAKE;
            end
            S_CLS_TAKE: begin
                o_cmd.op = OP_CLS_TAKE;
                n_state  = i_sts.cls_bad ? S_RESULT : S_MERGE_RD;
            end
            S_MERGE_RD: begin
                o_cmd.op = OP_MERGE_RD;
                n_state  = S_MERGE_WR;
            end
            S_MERGE_WR: begin
                o_cmd.op = OP_MERGE_WR;
                n_state  = i_sts.merge_more ? S_MERGE_RD : S_FREE_FIN;
            end
            S_FREE_FIN: begin
                o_cmd.op = OP_FREE_FIN;
                n_state  = S_RESULT;
            end
            S_RESULT: begin
                o_cmd.op = OP_PUSH;
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // A split or merge step never starts from idle, and each split or merge write follows its read
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |=> r_state == S_IDLE || r_state == S_SEL || r_state == S_CLS_RD)
        else $error("bad exit from idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SPLIT_WR |-> $past(r_state) == S_SPLIT_RD)
        else $error("split write without read");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MERGE_WR |-> $past(r_state) == S_MERGE_RD)
        else $error("merge write without read");
endmodule

// ----- hdl/bba_dp.sv -----
// Datapath of the buddy block allocator: bitmap and size class memories,
// free counts, used bytes, config and result registers.
// Depends on bba_pkg, bba_if and bba_ram.
module bba_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bba_pkg::t_cmd i_cmd,
    output bba_pkg::t_sts o_sts,
    bba_req_if.sink       i_req,
    bba_rsp_if.source     o_rsp,
    bba_cfg_if.sink       i_cfg
);
    import bba_pkg::*;

    // Configuration and bookkeeping
    logic [ADDR_W-1:0]    r_base;
    logic [HEAP_W-1:0]    r_heap;
    logic [HEAP_W-1:0]    r_used;
    logic [CNT_W-1:0]     r_cnt [LEVELS];
    logic [UNIT_BITS-1:0] r_clr;

    // Item registers
    logic [REQ_W-1:0]     r_req;
    logic [ADDR_W-1:0]    r_faddr;
    logic [19:0]          r_rel;
    logic [LVL_W-1:0]     r_want;
    logic [LVL_W-1:0]     r_lvl;
    logic [IDX_W-1:0]     r_idx;
    logic [BIT_W-1:0]     r_word;
    logic [1:0]           r_res_status;
    logic [ADDR_W-1:0]    r_res_addr;

    // Output register
    logic                 r_o_valid;
    logic [1:0]           r_o_status;
    logic [ADDR_W-1:0]    r_o_addr;

    // Memory ports
    logic                 bm_we;
    logic [BM_AW-1:0]     bm_addr;
    logic [WORD_W-1:0]    bm_wdata;
    logic [WORD_W-1:0]    bm_rdata;
    logic                 sc_we;
    logic [UNIT_BITS-1:0] sc_addr;
    logic [CLS_W-1:0]     sc_wdata;
    logic [CLS_W-1:0]     sc_rdata;

    // Decision signals
    logic [LVL_W-1:0]     w_want;
    logic                 w_too_large;
    logic [LVL_W-1:0]     w_found;
    logic                 w_any;
    logic [HEAP_W:0]      w_need;
    logic                 w_heap_bad;
    logic [ADDR_W-1:0]    w_rel;
    logic                 w_range_bad;
    logic                 w_cls_bad;
    logic                 w_hit;
    logic [BIT_W-1:0]     w_low;
    logic [BIT_W-1:0]     w_b;
    logic [WORD_W-1:0]    w_m0;
    logic [WORD_W-1:0]    w_m1;
    logic [WORD_W-1:0]    w_mbud;
    logic                 w_merge;
    logic [BM_AW-1:0]     w_cur_addr;
    logic [LVL_W-1:0]     w_lvl_dn;
    logic [IDX_W-1:0]     w_idx_dn;
    logic                 w_out_free;

    bba_ram #(.WIDTH(WORD_W), .DEPTH(BM_WORDS)) u_bitmap (
        .i_clk  (i_clk),
        .i_we   (bm_we),
        .i_addr (bm_addr),
        .i_wdata(bm_wdata),
        .o_rdata(bm_rdata)
    );

    bba_ram #(.WIDTH(CLS_W), .DEPTH(SC_DEPTH)) u_class (
        .i_clk  (i_clk),
        .i_we   (sc_we),
        .i_addr (sc_addr),
        .i_wdata(sc_wdata),
        .o_rdata(sc_rdata)
    );

    // Round the request up to a level
    always_comb begin
        w_want      = '0;
        w_too_large = 1'b1;
        for (int j = LEVELS - 1; j >= 0; j--) begin
            if (r_req <= REQ_W'(blk_bytes(LVL_W'(j)))) begin
                w_want      = LVL_W'(j);
                w_too_large = 1'b0;
            end
        end
    end

    // Find the first level at or above the wanted one with a free block
    always_comb begin
        w_found = '0;
        w_any   = 1'b0;
        for (int j = LEVELS - 1; j >= 0; j--) begin
            if (LVL_W'(j) >= w_want && r_cnt[j] != '0) begin
                w_found = LVL_W'(j);
                w_any   = 1'b1;
            end
        end
    end

    assign w_need     = {1'b0, r_used} + {1'b0, blk_bytes(w_want)};
    assign w_heap_bad = w_need > {1'b0, r_heap};

    assign w_rel       = r_faddr - r_base;
    assign w_range_bad = |w_rel[ADDR_W-1:20];
    assign w_cls_bad   = sc_rdata >= CLS_W'(LEVELS);

    // Lowest set bit of the scanned word
    assign w_hit = |bm_rdata;
    always_comb begin
        w_low = '0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (bm_rdata[k]) w_low = BIT_W'(k);
        end
    end

    assign w_b        = r_idx[BIT_W-1:0];
    assign w_m0       = WORD_W'(1) << w_b;
    assign w_m1       = WORD_W'(1) << {w_b[BIT_W-1:1], 1'b1};
    assign w_mbud     = WORD_W'(1) << (w_b ^ BIT_W'(1));
    assign w_merge    = (r_lvl != TOP_LEVEL) && |(bm_rdata & w_mbud);
    assign w_cur_addr = level_base(r_lvl) + BM_AW'(r_idx[IDX_W-1:BIT_W]);
    assign w_lvl_dn   = r_lvl - LVL_W'(1);
    assign w_idx_dn   = {r_idx[IDX_W-2:0], 1'b0};
    assign w_out_free = !r_o_valid || o_rsp.ready;

    // Memory controls
    always_comb begin
        bm_we    = 1'b0;
        bm_addr  = w_cur_addr;
        bm_wdata = bm_rdata;
        sc_we    = 1'b0;
        sc_addr  = r_rel[19:MIN_SHIFT];
        sc_wdata = CLASS_EMPTY;
        case (i_cmd.op)
            OP_CLEAR: begin
                bm_we    = r_clr < UNIT_BITS'(BM_WORDS);
                bm_addr  = r_clr[BM_AW-1:0];
                bm_wdata = (r_clr[BM_AW-1:0] == level_base(TOP_LEVEL)) ? WORD_W'(1) : '0;
                sc_we    = 1'b1;
                sc_addr  = r_clr;
            end
            OP_SCAN_RD, OP_SCAN_NEXT: begin
                bm_addr = level_base(r_lvl) + BM_AW'(r_word);
            end
            OP_SCAN_TAKE: begin
                bm_we    = 1'b1;
                bm_addr  = level_base(r_lvl) + BM_AW'(r_word);
                bm_wdata = bm_rdata & ~(WORD_W'(1) << w_low);
            end
            OP_SPLIT_RD: begin
                bm_addr = level_base(w_lvl_dn) + BM_AW'(w_idx_dn[IDX_W-1:BIT_W]);
            end
            OP_SPLIT_WR: begin
                bm_we    = 1'b1;
                bm_wdata = (bm_rdata & ~w_m0) | w_m1;
            end
            OP_CLS_RD: begin
                sc_addr = w_rel[19:MIN_SHIFT];
            end
            OP_CLS_TAKE: begin
                sc_we = !w_cls_bad;
            end
            OP_MERGE_WR: begin
                bm_we    = 1'b1;
                bm_wdata = w_merge ? (bm_rdata & ~w_m0 & ~w_mbud) : (bm_rdata | w_m0);
            end
            OP_ALLOC_FIN: begin
                sc_we    = 1'b1;
                sc_addr  = UNIT_BITS'(r_idx << r_want);
                sc_wdata = r_want;
            end
            default: ;
        endcase
    end

    // Hold configuration, free counts, used bytes and clearing pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_heap <= HEAP_W'(1 << 20);
            r_used <= '0;
            r_clr  <= '0;
            for (int j = 0; j < LEVELS; j++) begin
                r_cnt[j] <= (j == LEVELS - 1) ? CNT_W'(1) : '0;
            end
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_BASE: r_base <= i_cfg.data;
                    CFG_HEAP: r_heap <= i_cfg.data[HEAP_W-1:0];
                    default:  ;
                endcase
            end
            case (i_cmd.op)
                OP_CLEAR:     r_clr <= r_clr + UNIT_BITS'(1);
                OP_SCAN_TAKE: r_cnt[r_lvl] <= r_cnt[r_lvl] - CNT_W'(1);
                OP_SPLIT_WR:  r_cnt[r_lvl] <= r_cnt[r_lvl]
                                              - CNT_W'(|(bm_rdata & w_m0))
                                              + CNT_W'(!(|(bm_rdata & w_m1)));
                OP_MERGE_WR: begin
                    if (w_merge) begin
                        r_cnt[r_lvl] <= r_cnt[r_lvl] - CNT_W'(1)
                                        - CNT_W'(|(bm_rdata & w_m0));
                    end else begin
                        r_cnt[r_lvl] <= r_cnt[r_lvl] + CNT_W'(!(|(bm_rdata & w_m0)));
                    end
                end
                OP_ALLOC_FIN: r_used <= r_used + blk_bytes(r_want);
                OP_FREE_FIN:  r_used <= (r_used >= blk_bytes(r_want))
                                        ? r_used - blk_bytes(r_want) : '0;
                default: ;
            endcase
        end
    end

    // Item payload and result staging
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LATCH: begin
                if (i_req.valid) begin
                    r_req   <= i_req.request_bytes;
                    r_faddr <= i_req.free_address;
                end
            end
            OP_SEL: begin
                r_want       <= w_want;
                r_lvl        <= w_found;
                r_word       <= '0;
                r_res_addr   <= '0;
                r_res_status <= w_too_large ? ST_TOO_LARGE :
                                (w_heap_bad || !w_any) ? ST_NO_SPACE : ST_OK;
            end
            OP_SCAN_NEXT: r_word <= r_word + BIT_W'(1);
            OP_SCAN_TAKE: r_idx  <= {r_word, w_low};
            OP_SPLIT_RD: begin
                r_lvl <= w_lvl_dn;
                r_idx <= w_idx_dn;
            end
            OP_ALLOC_FIN: begin
                r_res_addr <= r_base + ADDR_W'({UNIT_BITS'(r_idx << r_want),
                                                 MIN_SHIFT'(0)});
            end
            OP_CLS_RD: begin
                r_rel        <= w_rel[19:0];
                r_res_addr   <= '0;
                r_res_status <= w_range_bad ? ST_BAD_FREE : ST_OK;
            end
            OP_CLS_TAKE: begin
                r_lvl  <= sc_rdata;
                r_want <= sc_rdata;
                r_idx  <= IDX_W'(r_rel >> (5'(MIN_SHIFT) + 5'(sc_rdata)));
                if (w_cls_bad) r_res_status <= ST_BAD_FREE;
            end
            OP_MERGE_WR: begin
                if (w_merge) begin
                    r_lvl <= r_lvl + LVL_W'(1);
                    r_idx <= {1'b0, r_idx[IDX_W-1:1]};
                end
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            if (o_rsp.ready) r_o_valid <= 1'b0;
            if (i_cmd.op == OP_PUSH && w_out_free) r_o_valid <= 1'b1;
        end
        if (i_cmd.op == OP_PUSH && w_out_free) begin
            r_o_status <= r_res_status;
            r_o_addr   <= r_res_addr;
        end
    end

    assign i_req.ready = i_cmd.in_ready;
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.block_address = r_o_addr;

    assign o_sts.in_valid   = i_req.valid;
    assign o_sts.in_kind    = i_req.kind;
    assign o_sts.clear_last = r_clr == CLEAR_LAST;
    assign o_sts.sel_fail   = w_too_large || w_heap_bad || !w_any;
    assign o_sts.word_hit   = w_hit;
    assign o_sts.split_more = r_lvl != r_want;
    assign o_sts.range_bad  = w_range_bad;
    assign o_sts.cls_bad    = w_cls_bad;
    assign o_sts.merge_more = w_merge;
    assign o_sts.out_free   = w_out_free;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_status != ST_OK |-> r_o_addr == '0)
        else $error("failed result carries an address");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used[MIN_SHIFT-1:0] == '0)
        else $error("used bytes not block aligned");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_SCAN_TAKE |-> r_cnt[r_lvl] != '0)
        else $error("free bit found at a level counted empty");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[LEVELS-1] <= CNT_W'(1))
        else $error("top level count above one");
endmodule

// ----- hdl/buddy_block_allocator.sv -----
// Buddy block allocator, top level. An allocate that is rejected goes straight to its result;
// else its time is set by the bitmap word scan (one 32-bit word at a time) and the split (one
// level at a time). A free with a bad address goes straight to its result; else its time is set
// by the merge (one level at a time). One item at a time, the next request taken only after the
// result registers; a held result stalls the following item only at its result stage.
// After reset a clearing pass runs with the request channel not ready.
// Depends on bba_pkg, bba_if, bba_ctrl and bba_dp.
module buddy_block_allocator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bba_req_if.sink    i_req,
    bba_rsp_if.source  o_rsp,
    bba_cfg_if.sink    i_cfg
);
    import bba_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bba_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    bba_dp u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd),
        .o_sts  (sts),
        .i_req  (i_req),
        .o_rsp  (o_rsp),
        .i_cfg  (i_cfg)
    );
endmodule
